/* hdl/assert_macros.svh */
// shared assertion helpers, clocked on clk and masked while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant that holds on every clock edge
`define ASSERT_AT(lbl, expr, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* hdl/stp_pkg.sv */
package stp_pkg;

	typedef enum logic [3:0] {
		CC_LETTER,
		CC_DIGIT,
		CC_UNDER,
		CC_LBR,
		CC_RBR,
		CC_DOT,
		CC_BSL,
		CC_QUOTE,
		CC_MINUS,
		CC_AT,
		CC_NUL,
		CC_OTHER
	} char_class_t;

	// classified character as it sits in the front queue
	typedef struct packed {
		logic        first;
		char_class_t cls;
		logic [3:0]  digit;
	} char_word_t;

	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_UNDER  = 8'h5f;
	localparam logic [7:0] CH_LBR    = 8'h5b;
	localparam logic [7:0] CH_RBR    = 8'h5d;
	localparam logic [7:0] CH_BSL    = 8'h5c;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_Z  = 8'h7a;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5a;

	localparam logic [1:0] KIND_NAME = 2'd0;
	localparam logic [1:0] KIND_STR  = 2'd1;
	localparam logic [1:0] KIND_NUM  = 2'd2;
	localparam logic [1:0] KIND_END  = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TOO_DEEP  = 3'd1;
	localparam logic [2:0] ST_UNTERM    = 3'd2;
	localparam logic [2:0] ST_STR_NORBR = 3'd3;
	localparam logic [2:0] ST_NUM_NORBR = 3'd4;
	localparam logic [2:0] ST_EMPTY     = 3'd5;
	localparam logic [2:0] ST_TOO_LONG  = 3'd6;

	localparam logic [31:0] SAT_LIMIT = 32'd214748365;
	localparam logic [31:0] NEG_MAX   = 32'h8000_0000;
	localparam logic [31:0] POS_MAX   = 32'h7fff_ffff;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  token_index;
		logic [7:0]  token_start;
		logic [7:0]  token_length;
		logic [31:0] int_value;
		logic [2:0]  status;
		logic [8:0]  consumed;
		logic        last;
	} result_t;

	// up to two results per character, r1 only with r0
	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} res_push_t;

endpackage

/* hdl/stp_front.sv */
module stp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         ch,
	input  logic               first,
	output logic               word_valid,
	input  logic               word_take,
	output stp_pkg::char_word_t word
);
	import stp_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW = $clog2(DEPTH);

	char_word_t       qmem [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      cnt_q;
	char_word_t       cw;
	logic             push, pop;

	always_comb begin
		cw.first = first;
		cw.digit = ch[3:0];
		if ((ch >= CH_LOW_A && ch <= CH_LOW_Z) || (ch >= CH_UP_A && ch <= CH_UP_Z)) begin
			cw.cls = CC_LETTER;
		end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
			cw.cls = CC_DIGIT;
		end else begin
			unique case (ch)
				CH_UNDER: cw.cls = CC_UNDER;
				CH_LBR:   cw.cls = CC_LBR;
				CH_RBR:   cw.cls = CC_RBR;
				CH_DOT:   cw.cls = CC_DOT;
				CH_BSL:   cw.cls = CC_BSL;
				CH_QUOTE: cw.cls = CC_QUOTE;
				CH_MINUS: cw.cls = CC_MINUS;
				CH_AT:    cw.cls = CC_AT;
				CH_NUL:   cw.cls = CC_NUL;
				default:  cw.cls = CC_OTHER;
			endcase
		end
	end

	assign in_ready   = (cnt_q != (AW+1)'(DEPTH));
	assign push       = in_valid && in_ready;
	assign word_valid = (cnt_q != '0);
	assign pop        = word_valid && word_take;
	assign word       = qmem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			qmem[wr_q] <= cw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

/* hdl/stp_back.sv */
`include "assert_macros.svh"

module stp_back #(
	parameter int MAX_TOKENS = 32,
	parameter int MAX_TEXT   = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                word_valid,
	output logic                word_take,
	input  stp_pkg::char_word_t word,
	input  logic                room,
	output stp_pkg::res_push_t  push
);
	import stp_pkg::*;

	localparam int PW = $clog2(MAX_TEXT + 1);
	localparam int CW = $clog2(MAX_TOKENS + 1);

	typedef enum logic [3:0] {
		M_IDLE, M_START, M_IDSTART, M_ID, M_OPEN, M_OPENBS, M_NUM, M_STR, M_STRQ, M_AFTER
	} mode_t;

	mode_t          mode_q, mode_v, mode_n;
	logic [PW-1:0]  pos_q, pos_v, pos_n;
	logic [PW-1:0]  begin_q, begin_v, begin_n, begin_src;
	logic [CW-1:0]  cnt_q, cnt_v, cnt_n;
	logic [31:0]    acc_q, acc_v, acc_n, acc_src, acc_next, acc_mul, num_val;
	logic           neg_q, neg_v, neg_n, neg_src;
	logic           pbs_q, pbs_v, pbs_n;
	logic           step, too_long;
	logic           do_idstart, do_openbs, do_num;
	logic           fin_req;
	logic [2:0]     fin_status;
	result_t        tok_r, fin_r;
	logic           tok_v;
	char_class_t    cls;

	assign step      = word_valid && room;
	assign word_take = step;
	assign cls       = word.cls;

	// a first flag restarts the parse from a clean state
	assign mode_v  = word.first ? M_START : mode_q;
	assign pos_v   = word.first ? '0 : pos_q;
	assign begin_v = word.first ? '0 : begin_q;
	assign cnt_v   = word.first ? '0 : cnt_q;
	assign acc_v   = word.first ? '0 : acc_q;
	assign neg_v   = word.first ? 1'b0 : neg_q;
	assign pbs_v   = word.first ? 1'b0 : pbs_q;

	assign too_long   = (pos_v >= PW'(MAX_TEXT)) && (cls != CC_NUL);
	assign do_idstart = (mode_v == M_IDSTART) || (mode_v == M_START && cls != CC_AT);
	assign do_openbs  = (mode_v == M_OPENBS) || (mode_v == M_OPEN && cls != CC_BSL);
	assign do_num     = (mode_v == M_NUM) ||
		(do_openbs && cls != CC_QUOTE && cls != CC_MINUS);

	// a number that starts on this character begins from zero
	assign acc_src   = (mode_v == M_NUM) ? acc_v : '0;
	assign neg_src   = (mode_v == M_NUM) ? neg_v : 1'b0;
	assign begin_src = (mode_v == M_NUM) ? begin_v : pos_v;

	// times ten plus digit, pinned at 2^31
	assign acc_mul = (acc_src << 3) + (acc_src << 1) + 32'(word.digit);
	assign acc_next = (acc_src >= SAT_LIMIT) ? NEG_MAX :
		((acc_mul > NEG_MAX) ? NEG_MAX : acc_mul);
	assign num_val = neg_src ? (32'd0 - acc_src) :
		((acc_src > POS_MAX) ? POS_MAX : acc_src);

	always_comb begin
		mode_n     = mode_v;
		begin_n    = begin_v;
		cnt_n      = cnt_v;
		acc_n      = acc_v;
		neg_n      = neg_v;
		pbs_n      = pbs_v;
		tok_v      = 1'b0;
		tok_r      = '0;
		fin_req    = 1'b0;
		fin_status = ST_OK;

		if (mode_v == M_IDLE) begin
			mode_n = M_IDLE;
		end else if (too_long) begin
			fin_req    = 1'b1;
			fin_status = ST_TOO_LONG;
		end else begin
			if (mode_v == M_START && cls == CC_AT) begin
				mode_n = M_IDSTART;
			end
			if (do_idstart) begin
				if (cls == CC_LETTER) begin
					if (cnt_v > CW'(MAX_TOKENS - 2)) begin
						fin_req    = 1'b1;
						fin_status = ST_TOO_DEEP;
					end else begin
						begin_n = pos_v;
						mode_n  = M_ID;
					end
				end else begin
					fin_req    = 1'b1;
					fin_status = (cnt_v == '0) ? ST_EMPTY : ST_OK;
				end
			end
			if (mode_v == M_ID &&
				cls != CC_LETTER && cls != CC_DIGIT && cls != CC_UNDER) begin
				tok_v              = 1'b1;
				tok_r.kind         = KIND_NAME;
				tok_r.token_start  = 8'(begin_v);
				tok_r.token_length = 8'(pos_v - begin_v);
				if (cls == CC_LBR) begin
					mode_n = M_OPEN;
				end else if (cls == CC_DOT) begin
					mode_n = M_IDSTART;
				end else begin
					fin_req = 1'b1;
				end
			end
			if (mode_v == M_OPEN && cls == CC_BSL) begin
				mode_n = M_OPENBS;
			end
			if (do_openbs) begin
				if (cls == CC_QUOTE) begin
					begin_n = pos_v + PW'(1);
					pbs_n   = 1'b0;
					mode_n  = M_STR;
				end else begin
					begin_n = pos_v;
					acc_n   = '0;
					neg_n   = (cls == CC_MINUS);
					mode_n  = M_NUM;
				end
			end
			if (do_num) begin
				if (cls == CC_DIGIT) begin
					acc_n  = acc_next;
					mode_n = M_NUM;
				end else if (cls == CC_RBR) begin
					tok_v              = 1'b1;
					tok_r.kind         = KIND_NUM;
					tok_r.token_start  = 8'(begin_src);
					tok_r.token_length = 8'(pos_v - begin_src);
					tok_r.int_value    = num_val;
					mode_n             = M_AFTER;
				end else begin
					fin_req    = 1'b1;
					fin_status = ST_NUM_NORBR;
				end
			end
			if (mode_v == M_STR) begin
				if (cls == CC_NUL) begin
					fin_req    = 1'b1;
					fin_status = ST_UNTERM;
				end else if (cls == CC_QUOTE) begin
					mode_n = M_STRQ;
				end else begin
					pbs_n = (cls == CC_BSL);
				end
			end
			if (mode_v == M_STRQ) begin
				if (cls == CC_RBR) begin
					// a backslash right before the closing quote is trimmed
					tok_v              = 1'b1;
					tok_r.kind         = KIND_STR;
					tok_r.token_start  = 8'(begin_v);
					tok_r.token_length = 8'(pos_v - PW'(1) - begin_v - PW'(pbs_v));
					mode_n             = M_AFTER;
				end else begin
					fin_req    = 1'b1;
					fin_status = ST_STR_NORBR;
				end
			end
			if (mode_v == M_AFTER) begin
				if (cls == CC_DOT) begin
					mode_n = M_IDSTART;
				end else begin
					fin_req = 1'b1;
				end
			end
		end

		if (tok_v) begin
			tok_r.token_index = 5'(cnt_v);
			cnt_n             = cnt_v + CW'(1);
		end
		if (fin_req) begin
			mode_n = M_IDLE;
		end
	end

	assign pos_n = (mode_n != M_IDLE) ? pos_v + PW'(1) : pos_v;

	always_comb begin
		fin_r          = '0;
		fin_r.kind     = KIND_END;
		fin_r.status   = fin_status;
		fin_r.consumed = 9'(pos_v);
		fin_r.last     = 1'b1;
	end

	always_comb begin
		push    = '0;
		push.r0 = tok_v ? tok_r : fin_r;
		push.r0.last = !(tok_v && fin_req);
		push.r1 = fin_r;
		push.v0 = step && (tok_v || fin_req);
		push.v1 = step && tok_v && fin_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pos_q   <= '0;
			begin_q <= '0;
			cnt_q   <= '0;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			pbs_q   <= 1'b0;
		end else if (step) begin
			mode_q  <= mode_n;
			pos_q   <= pos_n;
			begin_q <= begin_n;
			cnt_q   <= cnt_n;
			acc_q   <= acc_n;
			neg_q   <= neg_n;
			pbs_q   <= pbs_n;
		end
	end

	`ASSERT_AT(a_pos_bound, pos_q <= PW'(MAX_TEXT), "position ran past the text limit")
	`ASSERT_IMP(a_pair_ends, push.v1, push.r1.kind == KIND_END && push.r0.kind != KIND_END, "second result of a word is not an end record")
	`ASSERT_IMP(a_idle_quiet, step && mode_q == M_IDLE && !word.first, !push.v0, "result produced with no parse running")
	`ASSERT_IMP(a_push_room, push.v0, room, "result pushed without queue room")

endmodule

/* hdl/stp_outq.sv */
module stp_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  stp_pkg::res_push_t push,
	output logic               room,
	output logic               out_valid,
	input  logic               out_ready,
	output stp_pkg::result_t   out_res
);
	import stp_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW = $clog2(DEPTH);

	result_t        qmem [DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;
	logic           pop;
	logic [1:0]     nwr;

	// room for a full pair of results
	assign room      = (cnt_q <= (AW+1)'(DEPTH - 2));
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_res   = qmem[rd_q];
	assign nwr       = 2'(push.v0) + 2'(push.v1);

	always_ff @(posedge clk) begin
		if (push.v0) begin
			qmem[wr_q] <= push.r0;
		end
		if (push.v1) begin
			qmem[wr_q + AW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + AW'(nwr);
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			cnt_q <= cnt_q + (AW+1)'(nwr) - (AW+1)'(pop);
		end
	end

endmodule

/* hdl/select_path_tokenizer.sv */
// Select path tokenizer: takes one character of a dotted select path per word
// (tuser marks the first character of a new text, a zero byte ends it) and
// returns a token record for every identifier and every bracketed index,
// followed by an end record that carries the status and the character count.
// A character is taken every cycle while the front queue has space; the front
// classifies it into a 4-entry queue, the parser consumes one queued character
// per cycle while the result queue has room for two records and writes up to
// two records into a 4-entry result queue, which drains one record per cycle
// while m_tready is high. A record is offered only after its character has passed
// the front queue register and the record itself the result queue register.
module select_path_tokenizer #(
	parameter int MAX_TOKENS = 32,
	parameter int MAX_TEXT   = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // ch[7:0]
	input  logic        s_tuser,   // first
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // token_index[4:0], token_start[12:5], token_length[20:13],
	                               // int_value[52:21], status[55:53], consumed[64:56], zero pad
	output logic [1:0]  m_tuser,   // kind[1:0]
	output logic        m_tlast
);
	import stp_pkg::*;

	char_word_t word;
	logic       word_valid, word_take, room;
	res_push_t  push;
	result_t    out_res;

	stp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.ch         (s_tdata),
		.first      (s_tuser),
		.word_valid (word_valid),
		.word_take  (word_take),
		.word       (word)
	);

	stp_back #(
		.MAX_TOKENS (MAX_TOKENS),
		.MAX_TEXT   (MAX_TEXT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word_take  (word_take),
		.word       (word),
		.room       (room),
		.push       (push)
	);

	stp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {7'd0, out_res.consumed, out_res.status, out_res.int_value,
		out_res.token_length, out_res.token_start, out_res.token_index};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	import stp_pkg::*;

	localparam int MAX_TOKENS = 32;
	localparam int MAX_TEXT   = 256;
	localparam int QUIET_LIMIT = 5000;
	localparam int LONG_HOLD   = 300;
	localparam int CHAR_BUDGET = 300;

	typedef enum logic [3:0] {
		PM_IDLE,
		PM_START,
		PM_IDSTART,
		PM_ID,
		PM_OPEN,
		PM_OPENBS,
		PM_NUM,
		PM_STR,
		PM_STRQ,
		PM_AFTER
	} parse_mode_t;

	class token_scoreboard;
		result_t     expected_records[$];
		int          mismatches;
		parse_mode_t mode;
		logic [31:0] pos;
		logic [31:0] tbegin;
		logic [31:0] tcount;
		logic [31:0] acc;
		logic        neg;
		logic        prev_bs;

		function new();
			mismatches = 0;
			clear_parse();
		endfunction

		function void clear_parse();
			mode    = PM_IDLE;
			pos     = '0;
			tbegin  = '0;
			tcount  = '0;
			acc     = '0;
			neg     = 1'b0;
			prev_bs = 1'b0;
		endfunction

		function int pending();
			return expected_records.size();
		endfunction

		function void emit_token(logic [1:0] kind, logic [31:0] start, logic [31:0] len,
				logic [31:0] value);
			result_t r;
			r = '0;
			r.kind         = kind;
			r.token_index  = tcount[4:0];
			r.token_start  = start[7:0];
			r.token_length = len[7:0];
			r.int_value    = value;
			r.status       = ST_OK;
			expected_records.push_back(r);
			tcount++;
		endfunction

		function void end_parse(logic [2:0] status);
			result_t r;
			r = '0;
			r.kind     = KIND_END;
			r.status   = status;
			r.consumed = pos[8:0];
			expected_records.push_back(r);
			mode = PM_IDLE;
		endfunction

		function bit is_letter(logic [7:0] c);
			return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
		endfunction

		function bit is_digit(logic [7:0] c);
			return c >= CH_ZERO && c <= CH_NINE;
		endfunction

		// one accepted character word: work out the records it causes
		function void take_char(logic [7:0] c, logic f);
			int          n_before;
			bit          again;
			logic [31:0] value;
			n_before = expected_records.size();
			if (f) begin
				clear_parse();
				mode = PM_START;
			end
			if (mode == PM_IDLE)
				return;
			if (pos >= MAX_TEXT && c != CH_NUL) begin
				end_parse(ST_TOO_LONG);
			end else begin
				again = 1'b1;
				while (again) begin
					again = 1'b0;
					case (mode)
						PM_START: begin
							mode = PM_IDSTART;
							if (c != CH_AT)
								again = 1'b1;
						end
						PM_IDSTART: begin
							if (is_letter(c)) begin
								if (tcount > 32'(MAX_TOKENS - 2)) begin
									end_parse(ST_TOO_DEEP);
								end else begin
									tbegin = pos;
									mode   = PM_ID;
								end
							end else begin
								end_parse(tcount == 0 ? ST_EMPTY : ST_OK);
							end
						end
						PM_ID: begin
							if (!(is_letter(c) || is_digit(c) || c == CH_UNDER)) begin
								emit_token(KIND_NAME, tbegin, pos - tbegin, '0);
								if (c == CH_LBR)
									mode = PM_OPEN;
								else if (c == CH_DOT)
									mode = PM_IDSTART;
								else
									end_parse(ST_OK);
							end
						end
						PM_OPEN: begin
							mode = PM_OPENBS;
							if (c != CH_BSL)
								again = 1'b1;
						end
						PM_OPENBS: begin
							if (c == CH_QUOTE) begin
								tbegin  = pos + 1;
								prev_bs = 1'b0;
								mode    = PM_STR;
							end else begin
								tbegin = pos;
								acc    = '0;
								neg    = 1'b0;
								mode   = PM_NUM;
								if (c == CH_MINUS)
									neg = 1'b1;
								else
									again = 1'b1;
							end
						end
						PM_NUM: begin
							if (is_digit(c)) begin
								// saturate at 2^31 so that the negative extreme still fits
								if (acc >= SAT_LIMIT) begin
									acc = NEG_MAX;
								end else begin
									acc = acc * 10 + 32'(c - CH_ZERO);
									if (acc > NEG_MAX)
										acc = NEG_MAX;
								end
							end else if (c == CH_RBR) begin
								if (neg)
									value = -acc;
								else
									value = (acc > POS_MAX) ? POS_MAX : acc;
								emit_token(KIND_NUM, tbegin, pos - tbegin, value);
								mode = PM_AFTER;
							end else begin
								end_parse(ST_NUM_NORBR);
							end
						end
						PM_STR: begin
							if (c == CH_NUL)
								end_parse(ST_UNTERM);
							else if (c == CH_QUOTE)
								mode = PM_STRQ;
							else
								prev_bs = (c == CH_BSL);
						end
						PM_STRQ: begin
							if (c == CH_RBR) begin
								// a backslash right before the closing quote is trimmed
								emit_token(KIND_STR, tbegin, pos - 1 - tbegin - 32'(prev_bs), '0);
								mode = PM_AFTER;
							end else begin
								end_parse(ST_STR_NORBR);
							end
						end
						PM_AFTER: begin
							if (c == CH_DOT)
								mode = PM_IDSTART;
							else
								end_parse(ST_OK);
						end
						default: mode = PM_IDLE;
					endcase
				end
				if (mode != PM_IDLE)
					pos++;
			end
			if (expected_records.size() > n_before)
				expected_records[expected_records.size() - 1].last = 1'b1;
		endfunction

		function int field_diff(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, actual %0h", name, want, got);
				return 1;
			end
			return 0;
		endfunction

		function void check_record(result_t got);
			result_t want;
			if (expected_records.size() == 0) begin
				$error("record with no token expected: kind %0d", got.kind);
				mismatches++;
				return;
			end
			want = expected_records.pop_front();
			mismatches += field_diff("kind", want.kind, got.kind);
			mismatches += field_diff("token_index", want.token_index, got.token_index);
			mismatches += field_diff("token_start", want.token_start, got.token_start);
			mismatches += field_diff("token_length", want.token_length, got.token_length);
			mismatches += field_diff("int_value", want.int_value, got.int_value);
			mismatches += field_diff("status", want.status, got.status);
			mismatches += field_diff("consumed", want.consumed, got.consumed);
			mismatches += field_diff("last", want.last, got.last);
		endfunction
	endclass

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;   // ch[7:0]
	logic        s_tuser  = 1'b0; // first
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;         // token_index, token_start, token_length, int_value,
	                              // status, consumed, zero pad
	logic [1:0]  m_tuser;         // kind
	logic        m_tlast;

	token_scoreboard records = new();
	logic [7:0] path_chars[$];
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	bit hold_request   = 1'b0;
	int quiet_cycles   = 0;

	select_path_tokenizer #(
		.MAX_TOKENS(MAX_TOKENS),
		.MAX_TEXT  (MAX_TEXT)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// records are checked before the same edge's character word is noted
	always @(posedge clk) begin : watch_ports
		result_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got              = '0;
				got.kind         = m_tuser;
				got.token_index  = m_tdata[4:0];
				got.token_start  = m_tdata[12:5];
				got.token_length = m_tdata[20:13];
				got.int_value    = m_tdata[52:21];
				got.status       = m_tdata[55:53];
				got.consumed     = m_tdata[64:56];
				got.last         = m_tlast;
				records.check_record(got);
			end
			if (s_tvalid && s_tready)
				records.take_char(s_tdata, s_tuser);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver side: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else begin
				m_tready <= (int'($urandom_range(0, 99)) >= sink_stall_pct);
			end
		end
	end

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 1) == 1)
			return CH_LOW_A + 8'($urandom_range(0, 25));
		return CH_UP_A + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_text_char();
		logic [7:0] c;
		do begin
			if ($urandom_range(0, 7) == 0)
				c = 8'($urandom_range(1, 255));
			else
				c = 8'($urandom_range(32, 126));
		end while (c == CH_QUOTE);
		return c;
	endfunction

	// mostly well-formed path with random content into path_chars, sometimes ended by a random byte instead of a zero byte
	function automatic void build_path(input int nparts);
		int    n;
		string s;
		path_chars.delete();
		if ($urandom_range(0, 3) == 0)
			path_chars.push_back(CH_AT);
		for (int p = 0; p < nparts; p++) begin
			if (p != 0)
				path_chars.push_back(CH_DOT);
			path_chars.push_back(rand_letter());
			n = $urandom_range(0, 6);
			repeat (n) begin
				case ($urandom_range(0, 3))
					0: path_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
					1: path_chars.push_back(CH_UNDER);
					default: path_chars.push_back(rand_letter());
				endcase
			end
			if ($urandom_range(0, 1) == 1) begin
				path_chars.push_back(CH_LBR);
				if ($urandom_range(0, 3) == 0)
					path_chars.push_back(CH_BSL);
				if ($urandom_range(0, 1) == 1) begin
					path_chars.push_back(CH_QUOTE);
					n = $urandom_range(0, 5);
					repeat (n) path_chars.push_back(rand_text_char());
					if ($urandom_range(0, 2) == 0)
						path_chars.push_back(CH_BSL);
					path_chars.push_back(CH_QUOTE);
				end else begin
					if ($urandom_range(0, 1) == 1)
						path_chars.push_back(CH_MINUS);
					if ($urandom_range(0, 3) == 0) begin
						// values around the saturation points
						case ($urandom_range(0, 4))
							0: s = "2147483647";
							1: s = "2147483648";
							2: s = "2147483649";
							3: s = "214748365";
							default: s = "99999999999";
						endcase
						for (int i = 0; i < s.len(); i++)
							path_chars.push_back(s[i]);
					end else begin
						n = $urandom_range(0, 12);
						repeat (n) path_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
					end
				end
				path_chars.push_back(CH_RBR);
			end
		end
		if ($urandom_range(0, 7) == 0)
			path_chars.push_back(8'($urandom_range(1, 255)));
		else
			path_chars.push_back(CH_NUL);
	endfunction

	task automatic send_word(input logic [7:0] c, input logic f);
		while (int'($urandom_range(0, 99)) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tuser  <= f;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_text();
		for (int i = 0; i < path_chars.size(); i++)
			send_word(path_chars[i], i == 0);
	endtask

	task automatic send_string(input string s, input bit with_nul);
		path_chars.delete();
		for (int i = 0; i < s.len(); i++)
			path_chars.push_back(s[i]);
		if (with_nul)
			path_chars.push_back(CH_NUL);
		send_text();
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (records.pending() != 0) @(posedge clk);
	endtask

	initial begin
		int sent_chars;
		int text_no;
		int phase;
		int cur_phase;
		int cut;
		int n;
		bit long_done;
		sent_chars = 0;
		text_no    = 0;
		cur_phase  = -1;
		long_done  = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ignored word while idle, empty text, then the basic shapes
		send_word(8'hff, 1'b0);
		send_string("", 1'b1);
		send_string("@a.b[7]", 1'b1);
		send_string("x[\"q\\\"]", 1'b1);
		// restart in the middle of a name, negative index with no digits
		send_string("ab", 1'b0);
		send_string("Z[\\-]?", 1'b0);

		while (sent_chars < CHAR_BUDGET || !long_done) begin
			// every phase gets at least one text
			phase = sent_chars * 4 / CHAR_BUDGET;
			if (phase > cur_phase + 1)
				phase = cur_phase + 1;
			if (phase > 3)
				phase = 3;
			if (phase != cur_phase) begin
				wait_drain();
				cur_phase = phase;
				case (phase)
					0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
					1: begin src_idle_pct = 70; sink_stall_pct = 0;  end
					2: begin
						src_idle_pct   = 0;
						sink_stall_pct = 70;
						hold_request   = 1'b1;
					end
					default: begin src_idle_pct = 6; sink_stall_pct = 6; end
				endcase
			end
			text_no++;
			if (text_no == 3) begin
				// one name more than the token list holds
				path_chars.delete();
				for (int p = 0; p <= MAX_TOKENS; p++) begin
					if (p != 0)
						path_chars.push_back(CH_DOT);
					path_chars.push_back(rand_letter());
				end
				path_chars.push_back(CH_NUL);
				sent_chars += path_chars.size();
				send_text();
			end else if (phase == 3 && !long_done) begin
				// zero byte right at the text limit, or text running past it
				long_done = 1'b1;
				path_chars.delete();
				path_chars.push_back(CH_LOW_A);
				path_chars.push_back(CH_LBR);
				path_chars.push_back(CH_QUOTE);
				n = ($urandom_range(0, 1) == 1) ? MAX_TEXT - 5 : MAX_TEXT + 2;
				repeat (n) path_chars.push_back(rand_text_char());
				path_chars.push_back(CH_QUOTE);
				path_chars.push_back(CH_RBR);
				path_chars.push_back(CH_NUL);
				sent_chars += path_chars.size();
				send_text();
			end else begin
				build_path($urandom_range(1, 4));
				if ($urandom_range(0, 3) == 0 && path_chars.size() > 1) begin
					cut = $urandom_range(0, path_chars.size() - 1);
					case ($urandom_range(0, 2))
						0: path_chars[cut] = 8'($urandom_range(0, 255));
						1: begin
							while (path_chars.size() > cut + 1)
								void'(path_chars.pop_back());
							if ($urandom_range(0, 1) == 1)
								path_chars.push_back(CH_NUL);
						end
						default: path_chars.insert(cut, 8'($urandom_range(0, 255)));
					endcase
				end
				sent_chars += path_chars.size();
				send_text();
				if ($urandom_range(0, 5) == 0) begin
					n = $urandom_range(1, 3);
					sent_chars += n;
					repeat (n) send_word(8'($urandom_range(0, 255)), 1'b0);
				end
				if ($urandom_range(0, 11) == 0)
					wait_drain();
			end
		end

		wait_drain();
		repeat (8) @(posedge clk);
		if (records.mismatches == 0 && records.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* select_path_tokenizer.f */
+incdir+hdl
hdl/stp_pkg.sv
hdl/stp_front.sv
hdl/stp_back.sv
hdl/stp_outq.sv
hdl/select_path_tokenizer.sv
sim/testbench.sv
